// ===== hw/rtl/cbc_pkg.sv =====
// Shared constants and types for the color bin compaction block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int MAX_BINS  = 64;
    localparam int CFG_W     = 7;
    localparam int CFG_RESET = 64;
    localparam int PIX_W     = 8;
    localparam int N_W       = $clog2(MAX_BINS + 1);
    localparam int Q_W       = $clog2(MAX_BINS);
    localparam int MAP_DEPTH = MAX_BINS * MAX_BINS * MAX_BINS;
    localparam int RAW_W     = $clog2(MAP_DEPTH);
    localparam int IDX_W     = 18;
    localparam int USED_W    = 19;
    localparam int EPOCH_W   = 8;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // One classified pixel on its way to the map
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             first;
    } bin_req_t;

    typedef struct packed {
        logic     valid;
        bin_req_t item;
    } bin_push_t;

    // Back pressure seen by the front end
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              clearing;
    } fe_hold_t;

endpackage

// ===== hw/rtl/color_bin_compaction.sv =====
// Color bin compaction: a pixel passes the front-end registers, the queue and the map
// engine's idle, read and check states before done rises. The engine maps one pixel
// at a time by read-modify-write of the single-port bin map (read, check, write back).
// Results are strobed for one cycle on done; the receiver cannot stall them.
// Reset starts a clearing pass over all 262144 map words with busy high; the 255th
// frame start after a pass runs another such pass before that pixel is mapped.
`timescale 1ns / 1ps

module color_bin_compaction (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        first_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output logic        done,
    output logic [17:0] bin_index,
    output logic        is_new,
    output logic [18:0] used_bins
);
    import cbc_pkg::*;

    // Front end -> queue: one classified request per cycle at most
    bin_push_t         push;
    // Queue -> map engine
    bin_req_t          head;
    logic              head_valid;
    logic              pop;
    logic [QCNT_W-1:0] q_count;
    logic              clearing;
    // Hold the front end while the queue has no room or the map is being wiped
    fe_hold_t          hold;

    assign hold.count    = q_count;
    assign hold.clearing = clearing;

    // Quantize each channel, fold into a raw bin, drop it into the queue
    cbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .first_pixel (first_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .hold        (hold),
        .push        (push)
    );

    // Decouple the front end from the map engine
    cbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (q_count)
    );

    // Look up the raw bin, assign a compact index on first sight, strobe the result
    cbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .bin_index  (bin_index),
        .is_new     (is_new),
        .used_bins  (used_bins)
    );

endmodule

// ===== hw/rtl/cbc_front.sv =====
// Front end: bins-per-channel register, channel quantizers, raw bin index.
// Depends on cbc_pkg.
`timescale 1ns / 1ps

module cbc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [7:0]              blue,
    input  logic [7:0]              green,
    input  logic [7:0]              red,
    input  logic                    first_pixel,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [6:0]              cfg_data,
    input  cbc_pkg::fe_hold_t       hold,
    output cbc_pkg::bin_push_t      push
);
    import cbc_pkg::*;

    localparam int PROD_W = PIX_W + N_W;
    localparam int PG_W   = N_W + Q_W;
    localparam int PR_W   = 2 * N_W + Q_W;
    localparam int SUM_W  = PR_W + 1;

    function automatic logic [N_W-1:0] eff_bins(input logic [CFG_W-1:0] c);
        logic [N_W-1:0] n;
        if (c == '0)
            n = N_W'(1);
        else if (32'(c) > MAX_BINS)
            n = N_W'(MAX_BINS);
        else
            n = N_W'(c);
        return n;
    endfunction

    localparam logic [N_W-1:0]   N_RESET  = eff_bins(CFG_W'(CFG_RESET));
    localparam logic [2*N_W-1:0] NN_RESET = (2*N_W)'(N_RESET) * (2*N_W)'(N_RESET);

    logic [N_W-1:0]    n_reg;
    logic [2*N_W-1:0]  nn_reg;
    logic [N_W-1:0]    n_new;

    logic              a_valid_reg;
    logic [Q_W-1:0]    qb_a_reg, qg_a_reg, qr_a_reg;
    logic              first_a_reg;
    logic              b_valid_reg;
    logic [Q_W-1:0]    qb_b_reg;
    logic [PG_W-1:0]   pg_b_reg;
    logic [PR_W-1:0]   pr_b_reg;
    logic              first_b_reg;

    logic [PROD_W-1:0] prod_b, prod_g, prod_r;
    logic [SUM_W-1:0]  sum;
    logic [QCNT_W:0]   occupancy;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign n_new     = eff_bins(cfg_data);

    // Count items already committed to the queue so none can overflow it
    assign occupancy = {1'b0, hold.count} + (QCNT_W+1)'(a_valid_reg)
                     + (QCNT_W+1)'(b_valid_reg);
    assign busy      = hold.clearing || (32'(occupancy) >= QDEPTH);
    assign accept    = start && !busy;

    assign prod_b = PROD_W'(blue)  * PROD_W'(n_reg);
    assign prod_g = PROD_W'(green) * PROD_W'(n_reg);
    assign prod_r = PROD_W'(red)   * PROD_W'(n_reg);

    assign sum = SUM_W'(qb_b_reg) + SUM_W'(pg_b_reg) + SUM_W'(pr_b_reg);

    always_comb
    begin
        push.valid      = b_valid_reg;
        push.item.first = first_b_reg;
        if (sum >= SUM_W'(MAP_DEPTH))
            push.item.raw = RAW_W'(MAP_DEPTH - 1);
        else
            push.item.raw = sum[RAW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= N_RESET;
            nn_reg      <= NN_RESET;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                n_reg  <= n_new;
                nn_reg <= (2*N_W)'(n_new) * (2*N_W)'(n_new);
            end
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qb_a_reg    <= prod_b[PIX_W+Q_W-1:PIX_W];
            qg_a_reg    <= prod_g[PIX_W+Q_W-1:PIX_W];
            qr_a_reg    <= prod_r[PIX_W+Q_W-1:PIX_W];
            first_a_reg <= first_pixel;
        end
        if (a_valid_reg)
        begin
            qb_b_reg    <= qb_a_reg;
            pg_b_reg    <= PG_W'(n_reg) * PG_W'(qg_a_reg);
            pr_b_reg    <= PR_W'(nn_reg) * PR_W'(qr_a_reg);
            first_b_reg <= first_a_reg;
        end
    end

endmodule

// ===== hw/rtl/cbc_queue.sv =====
// Short request queue between front end and map engine.
// Depends on cbc_pkg.
`timescale 1ns / 1ps

module cbc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbc_pkg::bin_push_t      push,
    input  logic                    pop,
    output cbc_pkg::bin_req_t       head,
    output logic                    head_valid,
    output logic [cbc_pkg::QCNT_W-1:0] count
);
    import cbc_pkg::*;

    bin_req_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (32'(p) == QDEPTH - 1)
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push.valid && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push.valid)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            slot_reg[wr_ptr_reg] <= push.item;
    end

endmodule

// ===== hw/rtl/cbc_back.sv =====
// Map engine: epoch-tagged bin map, compact index counter, result register.
// Depends on cbc_pkg.
`timescale 1ns / 1ps

module cbc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cbc_pkg::bin_req_t           head,
    input  logic                        head_valid,
    output logic                        pop,
    output logic                        clearing,
    output logic                        done,
    output logic [17:0]                 bin_index,
    output logic                        is_new,
    output logic [18:0]                 used_bins
);
    import cbc_pkg::*;

    localparam int WORD_W = EPOCH_W + IDX_W;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK} state_t;

    state_t             state_reg;
    logic [RAW_W-1:0]   clr_cnt_reg;
    logic               resume_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [USED_W-1:0]  next_index_reg;
    logic [USED_W-1:0]  next_index_inc;
    logic [RAW_W-1:0]   raw_reg;
    logic               done_reg;
    logic [IDX_W-1:0]   bin_index_reg;
    logic               is_new_reg;
    logic [USED_W-1:0]  used_bins_reg;

    logic [WORD_W-1:0]  map_mem [MAP_DEPTH];
    logic [WORD_W-1:0]  rd_word_reg;
    logic               mem_we;
    logic [RAW_W-1:0]   mem_addr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               seen;

    assign seen           = (rd_word_reg[WORD_W-1:IDX_W] == epoch_reg);
    assign next_index_inc = next_index_reg + 1'b1;
    assign pop            = (state_reg == ST_IDLE) && head_valid;
    assign clearing       = (state_reg == ST_CLEAR);

    assign done      = done_reg;
    assign bin_index = bin_index_reg;
    assign is_new    = is_new_reg;
    assign used_bins = used_bins_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = raw_reg;
        mem_wdata = {epoch_reg, next_index_reg[IDX_W-1:0]};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:  mem_we = 1'b0;
            ST_READ:  mem_we = 1'b0;
            ST_CHECK: mem_we = !seen;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_addr] <= mem_wdata;
        else
            rd_word_reg <= map_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            resume_reg     <= 1'b0;
            epoch_reg      <= EPOCH_W'(1);
            next_index_reg <= '0;
            raw_reg        <= '0;
            done_reg       <= 1'b0;
            bin_index_reg  <= '0;
            is_new_reg     <= 1'b0;
            used_bins_reg  <= '0;
        end
        else
        begin
            done_reg <= (state_reg == ST_CHECK);
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (32'(clr_cnt_reg) == MAP_DEPTH - 1)
                    begin
                        clr_cnt_reg <= '0;
                        resume_reg  <= 1'b0;
                        state_reg   <= resume_reg ? ST_READ : ST_IDLE;
                    end
                    else
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        raw_reg <= head.raw;
                        if (head.first)
                        begin
                            next_index_reg <= '0;
                            // Out of fresh tags: wipe the map, then restart at tag one
                            if (epoch_reg == '1)
                            begin
                                epoch_reg  <= EPOCH_W'(1);
                                resume_reg <= 1'b1;
                                state_reg  <= ST_CLEAR;
                            end
                            else
                            begin
                                epoch_reg <= epoch_reg + 1'b1;
                                state_reg <= ST_READ;
                            end
                        end
                        else
                            state_reg <= ST_READ;
                    end
                end
                ST_READ:
                    state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    state_reg <= ST_IDLE;
                    if (seen)
                    begin
                        bin_index_reg <= rd_word_reg[IDX_W-1:0];
                        is_new_reg    <= 1'b0;
                        used_bins_reg <= next_index_reg;
                    end
                    else
                    begin
                        bin_index_reg  <= next_index_reg[IDX_W-1:0];
                        is_new_reg     <= 1'b1;
                        used_bins_reg  <= next_index_inc;
                        next_index_reg <= next_index_inc;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_CHECK))
        else $error("result strobe without a map check");

    a_new_bin_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !seen) |=> next_index_reg == $past(next_index_inc))
        else $error("new bin did not advance the index counter");

    a_new_index_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && is_new_reg) |-> used_bins_reg[IDX_W-1:0] == bin_index_reg + 1'b1)
        else $error("new bin index disagrees with used bin count");
`endif

endmodule
